@@ hdl/bbrt_pkg.sv @@
// ----------------------------------------------------------------------------
// bbrt_pkg: shared types and constants for the box transform
// Word formats, register codes, reset values and the per-axis arithmetic.
// ----------------------------------------------------------------------------
package bbrt_pkg;

    localparam int ROT_FRAC_BITS = 14;
    localparam int COORD_W       = 32;
    localparam int ENTRY_W       = 16;
    localparam int ROW_W         = 3 * ENTRY_W;
    localparam int PROD_W        = ENTRY_W + COORD_W;
    localparam int SUM_W         = PROD_W + 2;
    localparam int QUO_W         = SUM_W - ROT_FRAC_BITS;
    localparam int ADJ_W         = QUO_W + 1;
    localparam int AXES          = 3;
    localparam int ADDR_W        = 6;
    localparam int DATA_W        = 64;
    localparam int IDX_LSB       = 3;

    typedef enum logic [2:0] {
        REG_ROT_X = 3'd0,
        REG_ROT_Y = 3'd1,
        REG_ROT_Z = 3'd2,
        REG_LOC_X = 3'd3,
        REG_LOC_Y = 3'd4,
        REG_LOC_Z = 3'd5
    } t_reg_idx;

    localparam logic [ROW_W-1:0] ROT_X_RST = 48'h0000_0000_4000;
    localparam logic [ROW_W-1:0] ROT_Y_RST = 48'h0000_4000_0000;
    localparam logic [ROW_W-1:0] ROT_Z_RST = 48'h4000_0000_0000;

    typedef logic signed [COORD_W-1:0] t_coord;

    typedef struct packed {
        t_coord lo_x;
        t_coord lo_y;
        t_coord lo_z;
        t_coord hi_x;
        t_coord hi_y;
        t_coord hi_z;
    } t_box_in;

    typedef struct packed {
        t_coord out_lo_x;
        t_coord out_lo_y;
        t_coord out_lo_z;
        t_coord out_hi_x;
        t_coord out_hi_y;
        t_coord out_hi_z;
        logic   was_empty;
    } t_box_out;

    // rot[r] is the row for output axis r, loc[r] the offset along it
    typedef struct packed {
        logic [AXES-1:0][ROW_W-1:0]   rot;
        logic [AXES-1:0][COORD_W-1:0] loc;
    } t_cfg;

    // [r][c]: matrix entry (r,c) times column c of the low / high corner
    typedef struct packed {
        logic [AXES-1:0][AXES-1:0][PROD_W-1:0] plo;
        logic [AXES-1:0][AXES-1:0][PROD_W-1:0] phi;
        t_box_in                               box;
        logic                                  empty;
    } t_prod;

    // [r][c]: smaller and larger of the two products per term
    typedef struct packed {
        logic [AXES-1:0][AXES-1:0][PROD_W-1:0] mn;
        logic [AXES-1:0][AXES-1:0][PROD_W-1:0] mx;
        t_box_in                               box;
        logic                                  empty;
    } t_ext;

    function automatic logic signed [PROD_W-1:0] mul_entry(
        input logic signed [ENTRY_W-1:0] m,
        input logic signed [COORD_W-1:0] p
    );
        logic signed [PROD_W-1:0] a;
        logic signed [PROD_W-1:0] b;
        a = PROD_W'(m);
        b = PROD_W'(p);
        return PROD_W'(a * b);
    endfunction

    // sum three terms, round half up, add offset, saturate to 32 bits
    function automatic t_coord axis_map(
        input logic [AXES-1:0][PROD_W-1:0] v,
        input logic [COORD_W-1:0]          loc
    );
        logic signed [SUM_W-1:0] acc;
        logic signed [QUO_W-1:0] quo;
        logic signed [ADJ_W-1:0] adj;
        t_coord                  res;
        acc = SUM_W'($signed(v[0])) + SUM_W'($signed(v[1])) + SUM_W'($signed(v[2]))
            + SUM_W'(2 ** (ROT_FRAC_BITS - 1));
        quo = QUO_W'(acc >>> ROT_FRAC_BITS);
        adj = ADJ_W'(quo) + ADJ_W'($signed(loc));
        if (adj[ADJ_W-1:COORD_W-1] != {(ADJ_W-COORD_W+1){adj[ADJ_W-1]}}) begin
            res = adj[ADJ_W-1] ? t_coord'({1'b1, {(COORD_W-1){1'b0}}})
                               : t_coord'({1'b0, {(COORD_W-1){1'b1}}});
        end else begin
            res = adj[COORD_W-1:0];
        end
        return res;
    endfunction

endpackage

@@ hdl/bbrt_cfg.sv @@
// ----------------------------------------------------------------------------
// bbrt_cfg: configuration registers
// APB-style slave holding the three matrix rows and the translation.
// ----------------------------------------------------------------------------
module bbrt_cfg (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [bbrt_pkg::ADDR_W-1:0]    paddr,
    input  logic [bbrt_pkg::DATA_W-1:0]    pwdata,
    output logic [bbrt_pkg::DATA_W-1:0]    prdata,
    output logic                           pready,
    output bbrt_pkg::t_cfg                 o_cfg
);

    bbrt_pkg::t_cfg     r_cfg;
    bbrt_pkg::t_reg_idx idx;
    logic               wr_en;

    assign idx    = bbrt_pkg::t_reg_idx'(paddr[bbrt_pkg::ADDR_W-1:bbrt_pkg::IDX_LSB]);
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.rot[0] <= bbrt_pkg::ROT_X_RST;
            r_cfg.rot[1] <= bbrt_pkg::ROT_Y_RST;
            r_cfg.rot[2] <= bbrt_pkg::ROT_Z_RST;
            r_cfg.loc    <= '0;
        end else if (wr_en) begin
            case (idx)
                bbrt_pkg::REG_ROT_X: r_cfg.rot[0] <= pwdata[bbrt_pkg::ROW_W-1:0];
                bbrt_pkg::REG_ROT_Y: r_cfg.rot[1] <= pwdata[bbrt_pkg::ROW_W-1:0];
                bbrt_pkg::REG_ROT_Z: r_cfg.rot[2] <= pwdata[bbrt_pkg::ROW_W-1:0];
                bbrt_pkg::REG_LOC_X: r_cfg.loc[0] <= pwdata[bbrt_pkg::COORD_W-1:0];
                bbrt_pkg::REG_LOC_Y: r_cfg.loc[1] <= pwdata[bbrt_pkg::COORD_W-1:0];
                bbrt_pkg::REG_LOC_Z: r_cfg.loc[2] <= pwdata[bbrt_pkg::COORD_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (idx)
            bbrt_pkg::REG_ROT_X: prdata = bbrt_pkg::DATA_W'(r_cfg.rot[0]);
            bbrt_pkg::REG_ROT_Y: prdata = bbrt_pkg::DATA_W'(r_cfg.rot[1]);
            bbrt_pkg::REG_ROT_Z: prdata = bbrt_pkg::DATA_W'(r_cfg.rot[2]);
            bbrt_pkg::REG_LOC_X: prdata = bbrt_pkg::DATA_W'(r_cfg.loc[0]);
            bbrt_pkg::REG_LOC_Y: prdata = bbrt_pkg::DATA_W'(r_cfg.loc[1]);
            bbrt_pkg::REG_LOC_Z: prdata = bbrt_pkg::DATA_W'(r_cfg.loc[2]);
            default:             prdata = '0;
        endcase
    end

endmodule

@@ hdl/bbrt_mul.sv @@
// ----------------------------------------------------------------------------
// bbrt_mul: product stage
// Multiplies every matrix entry by the low and high coordinate of its column
// and flags empty boxes.
// ----------------------------------------------------------------------------
module bbrt_mul (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  bbrt_pkg::t_box_in i_box,
    input  bbrt_pkg::t_cfg    i_cfg,
    output logic              o_valid,
    input  logic              i_ready,
    output bbrt_pkg::t_prod   o_data
);

    logic                                                 r_valid;
    bbrt_pkg::t_prod                                      r_data;
    bbrt_pkg::t_prod                                      n_data;
    logic [bbrt_pkg::AXES-1:0][bbrt_pkg::COORD_W-1:0]     lo_v;
    logic [bbrt_pkg::AXES-1:0][bbrt_pkg::COORD_W-1:0]     hi_v;

    assign lo_v    = {i_box.lo_z, i_box.lo_y, i_box.lo_x};
    assign hi_v    = {i_box.hi_z, i_box.hi_y, i_box.hi_x};
    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_data  = r_data;

    always_comb begin
        n_data.box   = i_box;
        n_data.empty = ($signed(i_box.lo_x) > $signed(i_box.hi_x)) ||
                       ($signed(i_box.lo_y) > $signed(i_box.hi_y)) ||
                       ($signed(i_box.lo_z) > $signed(i_box.hi_z));
        for (int r = 0; r < bbrt_pkg::AXES; r++) begin
            for (int c = 0; c < bbrt_pkg::AXES; c++) begin
                n_data.plo[r][c] = bbrt_pkg::mul_entry(
                    $signed(i_cfg.rot[r][c*bbrt_pkg::ENTRY_W +: bbrt_pkg::ENTRY_W]),
                    $signed(lo_v[c]));
                n_data.phi[r][c] = bbrt_pkg::mul_entry(
                    $signed(i_cfg.rot[r][c*bbrt_pkg::ENTRY_W +: bbrt_pkg::ENTRY_W]),
                    $signed(hi_v[c]));
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_data <= n_data;
        end
    end

endmodule

@@ hdl/bbrt_ext.sv @@
// ----------------------------------------------------------------------------
// bbrt_ext: extreme stage
// Picks the smaller and larger product of each term; the box bounds are the
// sums of these, since each term depends on one column only.
// ----------------------------------------------------------------------------
module bbrt_ext (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  bbrt_pkg::t_prod i_data,
    output logic            o_valid,
    input  logic            i_ready,
    output bbrt_pkg::t_ext  o_data
);

    logic           r_valid;
    bbrt_pkg::t_ext r_data;
    bbrt_pkg::t_ext n_data;

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_data  = r_data;

    always_comb begin
        n_data.box   = i_data.box;
        n_data.empty = i_data.empty;
        for (int r = 0; r < bbrt_pkg::AXES; r++) begin
            for (int c = 0; c < bbrt_pkg::AXES; c++) begin
                if ($signed(i_data.plo[r][c]) < $signed(i_data.phi[r][c])) begin
                    n_data.mn[r][c] = i_data.plo[r][c];
                    n_data.mx[r][c] = i_data.phi[r][c];
                end else begin
                    n_data.mn[r][c] = i_data.phi[r][c];
                    n_data.mx[r][c] = i_data.plo[r][c];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_data <= n_data;
        end
    end

endmodule

@@ hdl/bbrt_sum.sv @@
// ----------------------------------------------------------------------------
// bbrt_sum: result stage
// Sums the extremes per axis, rounds, adds the translation and saturates;
// empty boxes pass through. Holds the output word.
// ----------------------------------------------------------------------------
module bbrt_sum (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  bbrt_pkg::t_ext     i_data,
    input  bbrt_pkg::t_cfg     i_cfg,
    output logic               o_valid,
    input  logic               i_ready,
    output bbrt_pkg::t_box_out o_data
);

    logic               r_valid;
    bbrt_pkg::t_box_out r_data;
    bbrt_pkg::t_box_out n_data;

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_data  = r_data;

    always_comb begin
        if (i_data.empty) begin
            n_data.out_lo_x  = i_data.box.lo_x;
            n_data.out_lo_y  = i_data.box.lo_y;
            n_data.out_lo_z  = i_data.box.lo_z;
            n_data.out_hi_x  = i_data.box.hi_x;
            n_data.out_hi_y  = i_data.box.hi_y;
            n_data.out_hi_z  = i_data.box.hi_z;
            n_data.was_empty = 1'b1;
        end else begin
            // rounding and saturation are monotone, so extremes map to extremes
            n_data.out_lo_x  = bbrt_pkg::axis_map(i_data.mn[0], i_cfg.loc[0]);
            n_data.out_lo_y  = bbrt_pkg::axis_map(i_data.mn[1], i_cfg.loc[1]);
            n_data.out_lo_z  = bbrt_pkg::axis_map(i_data.mn[2], i_cfg.loc[2]);
            n_data.out_hi_x  = bbrt_pkg::axis_map(i_data.mx[0], i_cfg.loc[0]);
            n_data.out_hi_y  = bbrt_pkg::axis_map(i_data.mx[1], i_cfg.loc[1]);
            n_data.out_hi_z  = bbrt_pkg::axis_map(i_data.mx[2], i_cfg.loc[2]);
            n_data.was_empty = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_data <= n_data;
        end
    end

endmodule

@@ hdl/bounding_box_rigid_transform_top.sv @@
// ----------------------------------------------------------------------------
// bounding_box_rigid_transform_top: axis-aligned box transform
//
//   channel   signals                          word
//   box in    i_valid, o_stall, i_box          t_box_in (min, max corner)
//   box out   o_valid, i_stall, o_box          t_box_out (bounds, was_empty)
//   config    psel/penable/pwrite/paddr/...    64-bit regs at 8*index
//
// One box per cycle sustained while i_stall is low; a word taken passes in turn
// through the product, extreme and result register stages.
// Each stage refills as soon as its word moves on, so input is taken while a
// result waits; o_stall rises only when all three stages are full and held.
// Synchronous active-low reset empties the pipeline and loads the identity
// matrix with zero translation.
// ----------------------------------------------------------------------------
module bounding_box_rigid_transform_top (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_stall,
    input  bbrt_pkg::t_box_in            i_box,
    output logic                         o_valid,
    input  logic                         i_stall,
    output bbrt_pkg::t_box_out           o_box,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [bbrt_pkg::ADDR_W-1:0]  paddr,
    input  logic [bbrt_pkg::DATA_W-1:0]  pwdata,
    output logic [bbrt_pkg::DATA_W-1:0]  prdata,
    output logic                         pready
);

    bbrt_pkg::t_cfg  cfg;
    bbrt_pkg::t_prod prod;
    bbrt_pkg::t_ext  ext;
    logic            mul_ready;
    logic            mul_valid;
    logic            ext_ready;
    logic            ext_valid;
    logic            sum_ready;

    assign o_stall = !mul_ready;

    bbrt_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    bbrt_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (mul_ready),
        .i_box   (i_box),
        .i_cfg   (cfg),
        .o_valid (mul_valid),
        .i_ready (ext_ready),
        .o_data  (prod)
    );

    bbrt_ext u_ext (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (mul_valid),
        .o_ready (ext_ready),
        .i_data  (prod),
        .o_valid (ext_valid),
        .i_ready (sum_ready),
        .o_data  (ext)
    );

    bbrt_sum u_sum (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (ext_valid),
        .o_ready (sum_ready),
        .i_data  (ext),
        .i_cfg   (cfg),
        .o_valid (o_valid),
        .i_ready (!i_stall),
        .o_data  (o_box)
    );

`ifndef SYNTHESIS
    // an empty output stage means every stage can take a word
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid |-> !o_stall)
        else $error("input stalled with empty pipeline");

    // a transformed box always has min <= max
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_box.was_empty) |->
        ($signed(o_box.out_lo_x) <= $signed(o_box.out_hi_x)) &&
        ($signed(o_box.out_lo_y) <= $signed(o_box.out_hi_y)) &&
        ($signed(o_box.out_lo_z) <= $signed(o_box.out_hi_z)))
        else $error("transformed box inverted");

    // a flagged box really is empty on some axis
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_box.was_empty) |->
        ($signed(o_box.out_lo_x) > $signed(o_box.out_hi_x)) ||
        ($signed(o_box.out_lo_y) > $signed(o_box.out_hi_y)) ||
        ($signed(o_box.out_lo_z) > $signed(o_box.out_hi_z)))
        else $error("empty flag on non-empty box");
`endif

endmodule
